/* rtl/qksp_pkg.sv */
// qksp_pkg: shared widths, codes, types and trend constants for the kernel switch policy
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package qksp_pkg;

   // field widths
   localparam int CONF_W   = 16;
   localparam int ENT_W    = 16;
   localparam int POS_W    = 16;
   localparam int KERN_W   = 3;
   localparam int REASON_W = 4;
   localparam int COUNT_W  = 16;
   localparam int SWCNT_W  = 8;

   // confidence history
   localparam int TREND_DEPTH = 5;
   localparam int NSEL_W      = $clog2(TREND_DEPTH + 1);
   localparam int TREND_W     = 36;
   localparam int EXIT_DEPTH  = 3;
   localparam int EXIT_SUM_W  = CONF_W + 2;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_CONF_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENT_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BUDGET       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_ENABLE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_MIN_CNT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_LEVEL   = 3'd6;

   // commands
   localparam logic CMD_EVALUATE = 1'b0;
   localparam logic CMD_RESTART  = 1'b1;

   // kernel codes
   localparam logic [KERN_W-1:0] KERNEL_LOW = 3'd1;
   localparam logic [KERN_W-1:0] KERNEL_MID = 3'd2;
   localparam logic [KERN_W-1:0] KERNEL_TOP = 3'd4;

   // reason codes
   localparam logic [REASON_W-1:0] REASON_EARLY    = 4'd0;
   localparam logic [REASON_W-1:0] REASON_BUDGET   = 4'd1;
   localparam logic [REASON_W-1:0] REASON_LOW_CONF = 4'd2;
   localparam logic [REASON_W-1:0] REASON_HIGH_ENT = 4'd3;
   localparam logic [REASON_W-1:0] REASON_TREND    = 4'd4;
   localparam logic [REASON_W-1:0] REASON_LOW_OK   = 4'd5;
   localparam logic [REASON_W-1:0] REASON_MID_OK   = 4'd6;
   localparam logic [REASON_W-1:0] REASON_TOP      = 4'd7;
   localparam logic [REASON_W-1:0] REASON_RESTART  = 4'd8;

   // slope limits as 1/div: kernel low -0.1, kernel mid -0.2
   localparam int TREND_DIV_LOW = 10;
   localparam int TREND_DIV_MID = 5;

   // reset values of the registers
   localparam logic [CONF_W-1:0]  RST_CONF_LIMIT   = 16'd45875;
   localparam logic [ENT_W-1:0]   RST_ENT_LIMIT    = 16'd768;
   localparam logic [POS_W-1:0]   RST_WARMUP       = 16'd0;
   localparam logic [SWCNT_W-1:0] RST_BUDGET       = 8'd2;
   localparam logic               RST_EXIT_ENABLE  = 1'b0;
   localparam logic [COUNT_W-1:0] RST_EXIT_MIN_CNT = 16'd0;
   localparam logic [CONF_W-1:0]  RST_EXIT_LEVEL   = 16'd62259;

   typedef struct packed {
      logic [CONF_W-1:0]  conf_limit;
      logic [ENT_W-1:0]   ent_limit;
      logic [POS_W-1:0]   warmup;
      logic [SWCNT_W-1:0] budget;
      logic               exit_enable;
      logic [COUNT_W-1:0] exit_min_count;
      logic [CONF_W-1:0]  exit_level;
   } cfg_type;

   typedef struct packed {
      logic                               command;
      logic [POS_W-1:0]                   position;
      logic [CONF_W-1:0]                  confidence;
      logic [ENT_W-1:0]                   entropy;
      logic [KERN_W-1:0]                  kernel;
   } item_type;

   typedef struct packed {
      logic [TREND_DEPTH-1:0][CONF_W-1:0] window;
      logic [COUNT_W-1:0]                 count;
      logic [SWCNT_W-1:0]                 switches;
   } hist_type;

   typedef struct packed {
      logic                restart;
      logic                record;
      logic                switched;
      logic [CONF_W-1:0]   confidence;
   } hist_upd_type;

   typedef struct packed {
      logic [KERN_W-1:0]   next_kernel;
      logic                switch_now;
      logic [REASON_W-1:0] reason_code;
      logic                exit_early;
   } result_type;

   // sum of x over x = 0 .. n-1
   function automatic int trend_sx(input int n);
      int s;
      s = 0;
      for (int i = 0; i < n; i++) begin
         s = s + i;
      end
      return s;
   endfunction

   // least-squares numerator weight of window entry a (newest first, x = n-1-a)
   function automatic int trend_weight(input int n, input int a);
      return n * (n - 1 - a) - trend_sx(n);
   endfunction

   // least-squares denominator n*sum(x^2) - (sum x)^2
   function automatic int trend_den(input int n);
      int sx2;
      sx2 = 0;
      for (int i = 0; i < n; i++) begin
         sx2 = sx2 + i * i;
      end
      return n * sx2 - trend_sx(n) * trend_sx(n);
   endfunction

endpackage

/* rtl/qksp_csr.sv */
// qksp_csr: configuration registers of the kernel switch policy
// depends on qksp_pkg
`timescale 1ns / 1ps

module qksp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qksp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qksp_pkg::CSR_DATA_W-1:0] csr_data,
   output qksp_pkg::cfg_type               cfg
);
   import qksp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CONF_LIMIT:   cfg_in.conf_limit     = csr_data[CONF_W-1:0];
            REG_ENT_LIMIT:    cfg_in.ent_limit      = csr_data[ENT_W-1:0];
            REG_WARMUP:       cfg_in.warmup         = csr_data[POS_W-1:0];
            REG_BUDGET:       cfg_in.budget         = csr_data[SWCNT_W-1:0];
            REG_EXIT_ENABLE:  cfg_in.exit_enable    = csr_data[0];
            REG_EXIT_MIN_CNT: cfg_in.exit_min_count = csr_data[COUNT_W-1:0];
            REG_EXIT_LEVEL:   cfg_in.exit_level     = csr_data[CONF_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_limit     <= RST_CONF_LIMIT;
         cfg_ff.ent_limit      <= RST_ENT_LIMIT;
         cfg_ff.warmup         <= RST_WARMUP;
         cfg_ff.budget         <= RST_BUDGET;
         cfg_ff.exit_enable    <= RST_EXIT_ENABLE;
         cfg_ff.exit_min_count <= RST_EXIT_MIN_CNT;
         cfg_ff.exit_level     <= RST_EXIT_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/qksp_history.sv */
// qksp_history: confidence window, saturating record count and switch count
// depends on qksp_pkg
`timescale 1ns / 1ps

module qksp_history (
   input  logic                   clock,
   input  logic                   reset,
   input  qksp_pkg::hist_upd_type upd,
   output qksp_pkg::hist_type     hist
);
   import qksp_pkg::*;

   hist_type hist_ff;
   hist_type hist_in;

   assign hist = hist_ff;

   always_comb begin
      hist_in = hist_ff;
      if (upd.restart) begin
         hist_in = '0;
      end else if (upd.record) begin
         for (int i = TREND_DEPTH - 1; i > 0; i--) begin
            hist_in.window[i] = hist_ff.window[i-1];
         end
         hist_in.window[0] = upd.confidence;
         if (hist_ff.count != {COUNT_W{1'b1}}) begin
            hist_in.count = hist_ff.count + COUNT_W'(1);
         end
         if (upd.switched && hist_ff.switches != {SWCNT_W{1'b1}}) begin
            hist_in.switches = hist_ff.switches + SWCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

/* rtl/qksp_decide.sv */
// qksp_decide: one-pass switch decision, trend test and early exit test
// depends on qksp_pkg
`timescale 1ns / 1ps

module qksp_decide (
   input  qksp_pkg::item_type     item,
   input  qksp_pkg::cfg_type      cfg,
   input  qksp_pkg::hist_type     hist,
   output qksp_pkg::result_type   result,
   output qksp_pkg::hist_upd_type upd
);
   import qksp_pkg::*;

   logic signed [TREND_W-1:0] num [TREND_DEPTH+1];
   logic [TREND_DEPTH:0]      below_low;
   logic [TREND_DEPTH:0]      below_mid;
   logic [NSEL_W-1:0]         n_sel;
   logic                      trend_ok;
   logic                      trend_low;
   logic                      trend_mid;
   logic [CONF_W+2:0]         conf_x5;
   logic [CONF_W+2:0]         limit_x4;
   logic [ENT_W+1:0]          ent_x2;
   logic [ENT_W+1:0]          limit_x3;
   logic [COUNT_W-1:0]        count_new;
   logic [1:0]                exit_k;
   logic [EXIT_SUM_W-1:0]     exit_sum;
   logic [EXIT_SUM_W-1:0]     exit_bound;
   logic                      switched;
   logic [REASON_W-1:0]       reason;
   logic [KERN_W-1:0]         next_kernel;

   // slope numerator for every window fill of three or more, with constant weights
   always_comb begin
      for (int n = 0; n <= TREND_DEPTH; n++) begin
         num[n]       = '0;
         below_low[n] = 1'b0;
         below_mid[n] = 1'b0;
      end
      for (int n = 3; n <= TREND_DEPTH; n++) begin
         for (int a = 0; a < n; a++) begin
            num[n] = num[n] + TREND_W'(trend_weight(n, a))
                     * $signed({{(TREND_W-CONF_W){1'b0}}, hist.window[a]});
         end
         below_low[n] = (num[n] * TREND_W'(TREND_DIV_LOW))
                        < -(TREND_W'(65536) * TREND_W'(trend_den(n)));
         below_mid[n] = (num[n] * TREND_W'(TREND_DIV_MID))
                        < -(TREND_W'(65536) * TREND_W'(trend_den(n)));
      end
   end

   assign n_sel     = (hist.count >= COUNT_W'(TREND_DEPTH)) ? NSEL_W'(TREND_DEPTH)
                                                          : hist.count[NSEL_W-1:0];
   assign trend_ok  = hist.count >= COUNT_W'(3);
   assign trend_low = trend_ok && below_low[n_sel];
   assign trend_mid = trend_ok && below_mid[n_sel];

   // mid kernel limits scaled: conf < 0.8 L, entropy > 1.5 E
   assign conf_x5  = ({3'b0, item.confidence} << 2) + {3'b0, item.confidence};
   assign limit_x4 = {3'b0, cfg.conf_limit} << 2;
   assign ent_x2   = {2'b0, item.entropy} << 1;
   assign limit_x3 = ({2'b0, cfg.ent_limit} << 1) + {2'b0, cfg.ent_limit};

   always_comb begin
      next_kernel = item.kernel;
      switched    = 1'b0;
      if (item.position < cfg.warmup) begin
         reason = REASON_EARLY;
      end else if (hist.switches >= cfg.budget) begin
         reason = REASON_BUDGET;
      end else if (item.kernel == KERNEL_LOW) begin
         switched    = 1'b1;
         next_kernel = KERNEL_MID;
         if (item.confidence < cfg.conf_limit) begin
            reason = REASON_LOW_CONF;
         end else if (item.entropy > cfg.ent_limit) begin
            reason = REASON_HIGH_ENT;
         end else if (trend_low) begin
            reason = REASON_TREND;
         end else begin
            reason      = REASON_LOW_OK;
            switched    = 1'b0;
            next_kernel = item.kernel;
         end
      end else if (item.kernel == KERNEL_MID) begin
         switched    = 1'b1;
         next_kernel = KERNEL_TOP;
         if (conf_x5 < limit_x4) begin
            reason = REASON_LOW_CONF;
         end else if (ent_x2 > limit_x3) begin
            reason = REASON_HIGH_ENT;
         end else if (trend_mid) begin
            reason = REASON_TREND;
         end else begin
            reason      = REASON_MID_OK;
            switched    = 1'b0;
            next_kernel = item.kernel;
         end
      end else begin
         reason = REASON_TOP;
      end
   end

   // early exit looks at the window after this token is recorded
   assign count_new = (hist.count == {COUNT_W{1'b1}}) ? hist.count
                                                      : hist.count + COUNT_W'(1);
   assign exit_k    = (count_new >= COUNT_W'(EXIT_DEPTH)) ? 2'(EXIT_DEPTH)
                                                          : count_new[1:0];
   assign exit_sum  = {2'b0, item.confidence}
                    + ((exit_k >= 2'd2) ? {2'b0, hist.window[0]} : '0)
                    + ((exit_k >= 2'd3) ? {2'b0, hist.window[1]} : '0);
   assign exit_bound = {2'b0, cfg.exit_level} * {{(EXIT_SUM_W-2){1'b0}}, exit_k};

   always_comb begin
      if (item.command == CMD_RESTART) begin
         result.next_kernel = item.kernel;
         result.switch_now  = 1'b0;
         result.reason_code = REASON_RESTART;
         result.exit_early  = 1'b0;
      end else begin
         result.next_kernel = next_kernel;
         result.switch_now  = switched;
         result.reason_code = reason;
         result.exit_early  = cfg.exit_enable && (count_new >= cfg.exit_min_count)
                              && (exit_sum > exit_bound);
      end
   end

   assign upd.restart    = item.command == CMD_RESTART;
   assign upd.record     = item.command == CMD_EVALUATE;
   assign upd.switched   = switched;
   assign upd.confidence = item.confidence;

endmodule

/* rtl/quant_kernel_switch_policy.sv */
// quant_kernel_switch_policy: top level of the per-token kernel switch policy
// depends on qksp_pkg, qksp_csr, qksp_history, qksp_decide
`timescale 1ns / 1ps

// The block takes one request per clock while req_stall is low and returns one
// response per request. An accepted request is registered first in the input
// register and then in the response register, which loads only when it is empty
// or being drained. The decision, the least-squares trend test over up to the last
// five recorded confidences and the early-exit average are worked out in a single
// combinational pass from the input register into the response register, and the
// history (confidence window, record count, switch count) is updated at the same
// edge the response is registered, so the following request always sees the
// history left by the one before it. Throughput is one request per cycle while
// the response side is not stalled, set by that one pass; a stalled response holds
// the result register and back-pressure reaches the request side only once the
// input register is also full. Configuration registers are written through the csr
// port, one per cycle, and should be written only while no request is in flight.
module quant_kernel_switch_policy (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [qksp_pkg::POS_W-1:0]      req_token_position,
   input  logic [qksp_pkg::CONF_W-1:0]     req_token_confidence,
   input  logic [qksp_pkg::ENT_W-1:0]      req_token_entropy,
   input  logic [qksp_pkg::KERN_W-1:0]     req_active_kernel,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [qksp_pkg::KERN_W-1:0]     rsp_next_kernel,
   output logic                            rsp_switch_now,
   output logic [qksp_pkg::REASON_W-1:0]   rsp_reason_code,
   output logic                            rsp_exit_early,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qksp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qksp_pkg::CSR_DATA_W-1:0] csr_data
);
   import qksp_pkg::*;

   cfg_type      cfg;
   hist_type     hist;
   hist_upd_type dec_upd;
   hist_upd_type hist_upd;
   result_type   dec_result;

   // input register
   logic         item_valid_ff;
   logic         item_valid_in;
   item_type     item_ff;

   // response register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   result_type   rsp_ff;

   logic         req_accept;
   logic         rsp_free;
   logic         item_go;

   // response register can take a new result when empty or being drained
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign item_go    = item_valid_ff && rsp_free;
   assign req_stall  = item_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   assign item_valid_in = req_accept || (item_valid_ff && !rsp_free);
   assign rsp_valid_in  = item_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.command    <= req_command;
         item_ff.position   <= req_token_position;
         item_ff.confidence <= req_token_confidence;
         item_ff.entropy    <= req_token_entropy;
         item_ff.kernel     <= req_active_kernel;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         rsp_ff <= dec_result;
      end
   end

   // history only moves when the item leaves for the response register
   assign hist_upd.restart    = item_go && dec_upd.restart;
   assign hist_upd.record     = item_go && dec_upd.record;
   assign hist_upd.switched   = dec_upd.switched;
   assign hist_upd.confidence = dec_upd.confidence;

   qksp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qksp_history u_history (
      .clock (clock),
      .reset (reset),
      .upd   (hist_upd),
      .hist  (hist)
   );

   qksp_decide u_decide (
      .item   (item_ff),
      .cfg    (cfg),
      .hist   (hist),
      .result (dec_result),
      .upd    (dec_upd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_kernel = rsp_ff.next_kernel;
   assign rsp_switch_now  = rsp_ff.switch_now;
   assign rsp_reason_code = rsp_ff.reason_code;
   assign rsp_exit_early  = rsp_ff.exit_early;

endmodule
